[hdl/e2q_pkg.sv]
// Shared types and constants for the Euler angle to quaternion pipeline.
// Holds the CORDIC arctangent table; no dependencies.
`default_nettype none
package e2q_pkg;
    localparam int CORDIC_STEPS = 32;
    localparam int CW = 34;                 // CORDIC datapath width, Q2.30 plus headroom
    localparam int ZW = 35;                 // residual angle width, 2^-32 turn
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    function automatic zval_t atan_turns(input int i);
        zval_t r;
        case (i)
            0: r = 35'sd536870912;  1: r = 35'sd316933406;  2: r = 35'sd167458907;
            3: r = 35'sd85004756;   4: r = 35'sd42667331;   5: r = 35'sd21354465;
            6: r = 35'sd10679838;   7: r = 35'sd5340245;    8: r = 35'sd2670163;
            9: r = 35'sd1335087;    10: r = 35'sd667544;    11: r = 35'sd333772;
            12: r = 35'sd166886;    13: r = 35'sd83443;     14: r = 35'sd41722;
            15: r = 35'sd20861;     16: r = 35'sd10430;     17: r = 35'sd5215;
            18: r = 35'sd2608;      19: r = 35'sd1304;      20: r = 35'sd652;
            21: r = 35'sd326;       22: r = 35'sd163;       23: r = 35'sd81;
            24: r = 35'sd41;        25: r = 35'sd20;        26: r = 35'sd10;
            27: r = 35'sd5;         28: r = 35'sd3;         29: r = 35'sd1;
            30: r = 35'sd1;         default: r = 35'sd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[hdl/euler_angles_to_quaternion_top.sv]
// Euler roll/pitch/yaw (Z-Y-X) to unit quaternion, top level.
// Uses e2q_pkg and e2q_cordic.
//
// Each word carries three signed binary angles (2^(ANGLE_BITS-1) is pi) and
// yields one quaternion word x, y, z, w in signed Q1.FRAC_BITS, rounded half
// up and clamped to plus or minus one. The pipeline takes one word per cycle
// while the output is not stalled. Each word passes through 39 register
// stages: 33 for the CORDIC (one per iteration plus input scaling), five for
// the pair products, the split triple products, the sums and the rounding,
// and one output register. A stall freezes the entire pipeline; the output
// register is a skid-free hold, so s_ready drops whenever the output word
// waits, whether or not the pipe holds other valid words.
`default_nettype none
module euler_angles_to_quaternion_top #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_roll_angle,
    input  wire logic signed [15:0] s_pitch_angle,
    input  wire logic signed [15:0] s_yaw_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_quat_x,
    output logic signed [15:0]      m_quat_y,
    output logic signed [15:0]      m_quat_z,
    output logic signed [15:0]      m_quat_w
);
    import e2q_pkg::*;

    localparam int LAT = CORDIC_STEPS + 1 + 5;   // stages before output register
    localparam int AW  = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int SH  = 60 - FRAC_BITS;

    // advance the whole pipe when the output can take a word
    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
            m_valid <= vld_reg[LAT-1];
        end
    end

    // angle bits above ANGLE_BITS are ignored; wider angles sign-extend from 16
    logic [ANGLE_BITS-1:0] ang_r, ang_p, ang_y;
    assign ang_r = ANGLE_BITS'($signed(s_roll_angle[AW-1:0]));
    assign ang_p = ANGLE_BITS'($signed(s_pitch_angle[AW-1:0]));
    assign ang_y = ANGLE_BITS'($signed(s_yaw_angle[AW-1:0]));

    cval_t cr, sr, cp, sp, cy, sy;
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .aclk(aclk), .adv(adv), .angle(ang_r), .cos_out(cr), .sin_out(sr));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .aclk(aclk), .adv(adv), .angle(ang_p), .cos_out(cp), .sin_out(sp));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .aclk(aclk), .adv(adv), .angle(ang_y), .cos_out(cy), .sin_out(sy));

    // stage 1: pair products floored to Q30
    logic signed [67:0] p1, p2, p3, p4;
    logic signed [CW-1:0] t1_reg, t2_reg, t3_reg, t4_reg, cy1_reg, sy1_reg;
    assign p1 = 68'(sr) * 68'(cp);
    assign p2 = 68'(cr) * 68'(sp);
    assign p3 = 68'(cr) * 68'(cp);
    assign p4 = 68'(sr) * 68'(sp);
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg  <= CW'(p1 >>> 30);
            t2_reg  <= CW'(p2 >>> 30);
            t3_reg  <= CW'(p3 >>> 30);
            t4_reg  <= CW'(p4 >>> 30);
            cy1_reg <= cy;
            sy1_reg <= sy;
        end
    end

    // stages 2-3: each triple product split into a high and a low half of the
    // yaw factor, 34x17 bits each, then recombined
    localparam int LO = 17;
    logic signed [CW-1:0] fq [8];
    // products: t1*cy, t2*sy, t2*cy, t1*sy, t3*sy, t4*cy, t3*cy, t4*sy
    logic signed [CW-1:0] fa [8];
    assign fa = '{t1_reg, t2_reg, t2_reg, t1_reg, t3_reg, t4_reg, t3_reg, t4_reg};
    assign fq = '{cy1_reg, sy1_reg, cy1_reg, sy1_reg, sy1_reg, cy1_reg, cy1_reg, sy1_reg};

    logic signed [CW+CW-LO:0] hi_reg [8];
    logic signed [CW+LO:0]    lo_reg [8];
    logic signed [69:0]       pr_reg [8];
    for (genvar k = 0; k < 8; k++) begin : g_tri
        always_ff @(posedge aclk) begin
            if (adv) begin
                hi_reg[k] <= (CW+CW-LO+1)'(fa[k]) * (CW+CW-LO+1)'(fq[k] >>> LO);
                lo_reg[k] <= (CW+LO+1)'(fa[k])
                             * (CW+LO+1)'($signed({1'b0, fq[k][LO-1:0]}));
                pr_reg[k] <= (70'(hi_reg[k]) <<< LO) + 70'(lo_reg[k]);
            end
        end
    end

    // stage 4: sums; stage 5: round and clamp
    logic signed [69:0] s_reg [4];
    logic signed [15:0] q_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            s_reg[0] <= pr_reg[0] - pr_reg[1];
            s_reg[1] <= pr_reg[2] + pr_reg[3];
            s_reg[2] <= pr_reg[4] - pr_reg[5];
            s_reg[3] <= pr_reg[6] + pr_reg[7];
        end
    end

    function automatic logic signed [15:0] finish(input logic signed [69:0] v);
        logic signed [69:0] r;
        logic signed [69:0] lim;
        lim = 70'sd1 <<< FRAC_BITS;
        r = (v + (70'sd1 <<< (SH - 1))) >>> SH;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) q_reg[k] <= finish(s_reg[k]);
        end
    end

    // output register holds while stalled
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_quat_x <= q_reg[0];
            m_quat_y <= q_reg[1];
            m_quat_z <= q_reg[2];
            m_quat_w <= q_reg[3];
        end
    end

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("ready low with empty output");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg) && m_valid)
        else $error("pipe moved during stall");
    a_valid_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[LAT-1]) |=> m_valid) else $error("word lost");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_w <= 16'sd16384 && m_quat_w >= -16'sd16384)
        || FRAC_BITS != 14) else $error("w out of range");
endmodule
`default_nettype wire

[hdl/e2q_cordic.sv]
// Pipelined rotation-mode CORDIC: cosine and sine of half a binary angle.
// One register stage per iteration; depends on e2q_pkg.
`default_nettype none
module e2q_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    adv,
    input  wire logic [ANGLE_BITS-1:0]   angle,
    output e2q_pkg::cval_t               cos_out,
    output e2q_pkg::cval_t               sin_out
);
    import e2q_pkg::*;

    cval_t x_reg [CORDIC_STEPS+1];
    cval_t y_reg [CORDIC_STEPS+1];
    zval_t z_reg [CORDIC_STEPS];

    // scale the angle to 2^-32 turn
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0] <= CORDIC_GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= zval_t'({{(ZW-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle})
                        <<< (32 - ANGLE_BITS);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                end
            end
        end

        // the residual after the last step is not needed
        if (i < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (z_reg[i] >= 0) begin
                        z_reg[i+1] <= z_reg[i] - (atan_turns(i) <<< 1);
                    end else begin
                        z_reg[i+1] <= z_reg[i] + (atan_turns(i) <<< 1);
                    end
                end
            end
        end
    end

    assign cos_out = x_reg[CORDIC_STEPS];
    assign sin_out = y_reg[CORDIC_STEPS];
endmodule
`default_nettype wire

[verif/euler_angles_to_quaternion_top_tb.sv]
// Testbench for euler_angles_to_quaternion_top: drives roll/pitch/yaw words and
// checks each quaternion word against a bit-exact CORDIC predictor.
// Depends on e2q_pkg (arctangent table, CORDIC gain) and the top-level RTL.
`timescale 1ns / 100ps
`default_nettype none
module euler_angles_to_quaternion_top_tb;
    import e2q_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_roll_angle;
    logic signed [15:0] s_pitch_angle;
    logic signed [15:0] s_yaw_angle;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_quat_x;
    logic signed [15:0] m_quat_y;
    logic signed [15:0] m_quat_z;
    logic signed [15:0] m_quat_w;

    quat_t pending_quats[$];
    int    error_count = 0;
    bit    no_idle     = 1'b0;   // when set, neither side inserts gaps or stalls
    int    stall_left  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    euler_angles_to_quaternion_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_roll_angle  (s_roll_angle),
        .s_pitch_angle (s_pitch_angle),
        .s_yaw_angle   (s_yaw_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quat_x      (m_quat_x),
        .m_quat_y      (m_quat_y),
        .m_quat_z      (m_quat_z),
        .m_quat_w      (m_quat_w)
    );

    // Cosine and sine (Q2.30) of half of a binary angle given in 2^-32 turn.
    // Each step subtracts twice the arctangent entry, so the rotation lands on
    // the half angle; shifts are arithmetic (floor), a zero residual rotates up.
    function automatic void half_angle_sincos(input longint turns,
                                              output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = longint'(CORDIC_GAIN_INV);
        y = 0;
        z = turns;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - 2 * longint'(atan_turns(i));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + 2 * longint'(atan_turns(i));
            end
        end
        c = x;
        s = y;
    endfunction

    // Round a Q60 sum half up to Q1.14 and clamp to plus or minus one.
    function automatic logic signed [15:0] round_to_q14(input longint q60);
        longint r;
        r = (q60 + (longint'(1) <<< 45)) >>> 46;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic quat_t euler_to_quat(input logic signed [15:0] roll,
                                            input logic signed [15:0] pitch,
                                            input logic signed [15:0] yaw);
        longint cr, sr, cp, sp, cy, sy, srcp, crsp, crcp, srsp;
        quat_t  q;
        half_angle_sincos(longint'(roll) * 65536, cr, sr);
        half_angle_sincos(longint'(pitch) * 65536, cp, sp);
        half_angle_sincos(longint'(yaw) * 65536, cy, sy);
        srcp = (sr * cp) >>> 30;
        crsp = (cr * sp) >>> 30;
        crcp = (cr * cp) >>> 30;
        srsp = (sr * sp) >>> 30;
        q.x = round_to_q14(srcp * cy - crsp * sy);
        q.y = round_to_q14(crsp * cy + srcp * sy);
        q.z = round_to_q14(crcp * sy - srsp * cy);
        q.w = round_to_q14(crcp * cy + srsp * sy);
        return q;
    endfunction

    // Present one angle word after a random gap and hold it until accepted.
    // The expected quaternion is queued at the accepting edge.
    task automatic send_angles(input logic signed [15:0] roll,
                               input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 19));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_roll_angle  <= roll;
        s_pitch_angle <= pitch;
        s_yaw_angle   <= yaw;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_quats.push_back(euler_to_quat(roll, pitch, yaw));
    endtask

    // Drop valid after the last word, on the edge following its acceptance.
    task automatic idle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Sweep the field extremes and quarter turns on every axis, including the
    // all-zero word whose w lands exactly on the saturation bound.
    task automatic test_extreme_angles();
        logic signed [15:0] corners[6] = '{16'sd0, -16'sd32768, 16'sd32767,
                                           16'sd16384, -16'sd16384, -16'sd1};
        foreach (corners[i]) begin
            send_angles(corners[i], 16'sd0, 16'sd0);
            send_angles(16'sd0, corners[i], 16'sd0);
            send_angles(16'sd0, 16'sd0, corners[i]);
        end
        send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
        send_angles(16'sd32767, 16'sd32767, 16'sd32767);
        send_angles(16'sd16384, 16'sd16384, 16'sd16384);
        send_angles(16'sh5555, -16'sh5556, 16'sh2AAA);
    endtask

    // Random angles, alternating stretches with and without idling. A share
    // of angles picks near-extreme values so that sign boundaries stay hit.
    task automatic test_random_angles(input int count);
        logic signed [15:0] a[3];
        for (int n = 0; n < count; n++) begin
            if (n % 250 == 0)
                no_idle = (((n / 250) % 2) == 1);
            foreach (a[k]) begin
                if ($urandom_range(0, 7) == 0)
                    a[k] = $urandom_range(0, 1)
                         ? 16'sd32767 - 16'($urandom_range(0, 3))
                         : -16'sd32768 + 16'($urandom_range(0, 3));
                else
                    a[k] = 16'($urandom);
            end
            send_angles(a[0], a[1], a[2]);
        end
        no_idle = 1'b0;
    endtask

    // Receiver: after each accepted word, hold m_ready low for a random stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if (m_valid && m_ready) begin
            int stall;
            stall = no_idle ? 0 : int'($urandom_range(0, 19));
            stall_left <= stall;
            m_ready    <= (stall == 0);
        end
    end

    // Compare each accepted quaternion word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_quats.size() == 0) begin
                $error("unexpected quaternion word x=%0d y=%0d z=%0d w=%0d",
                       m_quat_x, m_quat_y, m_quat_z, m_quat_w);
                error_count++;
            end else begin
                quat_t q;
                q = pending_quats.pop_front();
                if (m_quat_x !== q.x) begin
                    $error("quat_x expected %0d actual %0d", q.x, m_quat_x);
                    error_count++;
                end
                if (m_quat_y !== q.y) begin
                    $error("quat_y expected %0d actual %0d", q.y, m_quat_y);
                    error_count++;
                end
                if (m_quat_z !== q.z) begin
                    $error("quat_z expected %0d actual %0d", q.z, m_quat_z);
                    error_count++;
                end
                if (m_quat_w !== q.w) begin
                    $error("quat_w expected %0d actual %0d", q.w, m_quat_w);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_roll_angle  <= '0;
        s_pitch_angle <= '0;
        s_yaw_angle   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_angles();
        test_random_angles(2000);
        idle_input();

        // Drain: wait for every expected word, then let the pipe settle.
        while (pending_quats.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (error_count == 0)
            $display("euler_angles_to_quaternion_top_tb passed");
        else
            $display("euler_angles_to_quaternion_top_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 2000 words.
    initial begin
        #20ms;
        $display("euler_angles_to_quaternion_top_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
